FILE: rtl/mtg_pkg.sv
// Package for the MT19937 generator: table geometry, scheme constants,
// and the twist and tempering functions. It has no dependencies.
`timescale 1ns / 1ps
package mtg_pkg;

    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned SHIFT_DIST  = 397;
    localparam int unsigned POS_W       = $clog2(STATE_WORDS);

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(STATE_WORDS - 1);
    localparam logic [POS_W-1:0] FAR_FWD    = POS_W'(SHIFT_DIST);
    localparam logic [POS_W-1:0] FAR_WRAP   = POS_W'(STATE_WORDS - SHIFT_DIST);

    localparam logic [31:0] INIT_MULT  = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
    localparam logic [31:0] SEED_RESET = 32'd5489;

    localparam int unsigned ADDR_W = 3;
    // Register index, taken from the word-address bit of paddr.
    localparam logic REG_SEED = 1'b0;

    // Twist one word: top bit of word i, low 31 bits of word i+1, far word.
    function automatic logic [31:0] twist_word(input logic [31:0] here,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] w;
        y = {here[31], nxt[30:0]};
        w = far ^ (y >> 1);
        if (y[0])
        begin
            w = w ^ TWIST_XOR;
        end
        return w;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: rtl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: state table memory, seed fill,
// incremental twist, tempering and output buffering. Depends on mtg_pkg.
`timescale 1ns / 1ps
// Usage
// -----
// The request channel (in_valid, in_ready, draw_request) takes one request a
// cycle while in_ready is high. A request with draw_request high returns one
// tempered 32-bit word on the result channel (out_valid, out_ready,
// random_word); a request with draw_request low is taken and returns nothing.
// Each word is registered in the output or skid register; the sustained rate
// is one word per cycle while out_ready is high and no fill runs. The 624-word
// state table lives in a memory with one write port and two registered read
// ports. Rather than twisting the whole table before every 624th draw, each
// draw twists just the word it returns, which gives the same sequence; the
// reads for the next position are issued ahead of its request. At reset, and
// after every write of the seed register (APB, paddr[2] low), the table is
// refilled by the initialisation multiply chain, one word per cycle, during
// which in_ready is low. Results held in the output buffer are kept across a
// seed write. When the receiver stalls, the output register holds the word and
// a skid register takes one more; in_ready drops only once both are full.
module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              draw_request,
    // Result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       random_word,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // State table and its registered read data.
    logic [31:0] table_mem [STATE_WORDS];
    logic [31:0] rd_nxt_reg;
    logic [31:0] rd_far_reg;

    // Control registers.
    logic [31:0]      seed_reg;
    logic             fill_active_reg;
    logic [POS_W-1:0] fill_idx_reg;
    logic [31:0]      fill_prev_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      cur_reg;
    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             skid_valid_reg;
    logic [31:0]      skid_data_reg;

    logic             seed_write;
    logic             draw_fire;
    logic [31:0]      fill_word;
    logic [31:0]      twisted;
    logic [31:0]      result;
    logic             mem_we;
    logic [POS_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [POS_W-1:0] rd_nxt_addr;
    logic [POS_W-1:0] rd_far_addr;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;
    assign seed_write = psel && penable && pwrite && (paddr[2] == REG_SEED);

    assign in_ready    = !fill_active_reg && !skid_valid_reg;
    assign draw_fire   = in_valid && in_ready && draw_request;
    assign out_valid   = out_valid_reg;
    assign random_word = out_data_reg;

    // Initialisation chain: w[i] = 1812433253 * (w[i-1] ^ (w[i-1] >> 30)) + i.
    always_comb
    begin
        if (fill_idx_reg == '0)
        begin
            fill_word = seed_reg;
        end
        else
        begin
            fill_word = INIT_MULT * (fill_prev_reg ^ (fill_prev_reg >> 30))
                        + {{(32-POS_W){1'b0}}, fill_idx_reg};
        end
    end

    // The word at the current position is twisted in place. Words below it
    // are already new, words above are still old, exactly as a full twist
    // would see them when it reaches this word.
    assign twisted = twist_word(cur_reg, rd_nxt_reg, rd_far_reg);
    assign result  = temper(twisted);

    always_comb
    begin
        pos_next = pos_reg;
        if (draw_fire)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
    end

    // Reads for the position of the next request, registered ahead of it.
    assign rd_nxt_addr = (pos_next == LAST_POS) ? '0 : pos_next + 1'b1;
    assign rd_far_addr = (pos_next >= FAR_WRAP) ? pos_next - FAR_WRAP
                                                : pos_next + FAR_FWD;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = twisted;
        if (fill_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_idx_reg;
            mem_wdata = fill_word;
        end
        else if (draw_fire)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_nxt_reg <= table_mem[rd_nxt_addr];
        rd_far_reg <= table_mem[rd_far_addr];
    end

    // Seed register and table fill sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= SEED_RESET;
            fill_active_reg <= 1'b1;
            fill_idx_reg    <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (seed_write)
            begin
                seed_reg        <= pwdata;
                fill_active_reg <= 1'b1;
                fill_idx_reg    <= '0;
                pos_reg         <= '0;
            end
            else if (fill_active_reg)
            begin
                if (fill_idx_reg == LAST_POS)
                begin
                    fill_active_reg <= 1'b0;
                    fill_idx_reg    <= '0;
                end
                else
                begin
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                end
            end
        end
    end

    // Previous fill word and the old word at the current position.
    always_ff @(posedge clk)
    begin
        if (fill_active_reg)
        begin
            fill_prev_reg <= fill_word;
            if (fill_idx_reg == '0)
            begin
                cur_reg <= fill_word;
            end
        end
        else if (draw_fire)
        begin
            cur_reg <= rd_nxt_reg;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= draw_fire;
                end
            end
            else if (draw_fire)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
        else if (draw_fire)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

endmodule
